/* rtl/bfnn_pkg.sv */
// ----------------------------------------------------------------------------
// bfnn_pkg
// shared constants, codes and types of the nearest neighbor search core
// ----------------------------------------------------------------------------
package bfnn_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int OP_W        = 2;
    localparam int COORD_W     = 16;
    localparam int DIST_W      = 36;
    localparam int MATCH_IDX_W = 10;
    localparam int SQ_W        = 2 * COORD_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int POINT_W     = 3 * COORD_W;

    localparam logic [DIST_W-1:0] CUTOFF_RESET = DIST_W'(6553600);

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } bfnn_tag_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FIN
    } bfnn_state_t;

endpackage

/* rtl/bfnn_if.sv */
// ----------------------------------------------------------------------------
// bfnn_if
// command, result and configuration channels of the nearest neighbor core
// ----------------------------------------------------------------------------
interface bfnn_cmd_if;
    import bfnn_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     opcode;
    coord_t              coord_x;
    coord_t              coord_y;
    coord_t              coord_z;

    modport source (output valid, output opcode, output coord_x, output coord_y,
                    output coord_z, input ready);
    modport sink   (input valid, input opcode, input coord_x, input coord_y,
                    input coord_z, output ready);
endinterface

interface bfnn_result_if;
    import bfnn_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [MATCH_IDX_W-1:0] match_index;
    logic [DIST_W-1:0]      match_distance;
    logic                   found;

    modport source (output valid, output match_index, output match_distance,
                    output found, input ready);
    modport sink   (input valid, input match_index, input match_distance,
                    input found, output ready);
endinterface

interface bfnn_cfg_if;
    import bfnn_pkg::*;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/bfnn_ram.sv */
// ----------------------------------------------------------------------------
// bfnn_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bfnn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bfnn_dist.sv */
// ----------------------------------------------------------------------------
// bfnn_dist
// two stage squared distance unit, one stored point per cycle
// ----------------------------------------------------------------------------
module bfnn_dist import bfnn_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  bfnn_tag_t         in_tag,
    input  coord_t            qx,
    input  coord_t            qy,
    input  coord_t            qz,
    input  coord_t            rx,
    input  coord_t            ry,
    input  coord_t            rz,
    output bfnn_tag_t         res_tag,
    output logic [DIST_W-1:0] res_dist,
    output logic              busy
);

    logic signed [COORD_W:0]     dx;
    logic signed [COORD_W:0]     dy;
    logic signed [COORD_W:0]     dz;
    logic signed [2*COORD_W+1:0] px;
    logic signed [2*COORD_W+1:0] py;
    logic signed [2*COORD_W+1:0] pz;

    bfnn_tag_t        s1_tag_reg;
    bfnn_tag_t        s2_tag_reg;
    logic [SQ_W-1:0]  sqx_reg;
    logic [SQ_W-1:0]  sqy_reg;
    logic [SQ_W-1:0]  sqz_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;

    always_comb
    begin
        dx = {qx[COORD_W-1], qx} - {rx[COORD_W-1], rx};
        dy = {qy[COORD_W-1], qy} - {ry[COORD_W-1], ry};
        dz = {qz[COORD_W-1], qz} - {rz[COORD_W-1], rz};
        px = dx * dx;
        py = dy * dy;
        pz = dz * dz;
        sum_next = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
        end
        else
        begin
            s1_tag_reg <= in_tag;
            s2_tag_reg <= s1_tag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sqx_reg <= px[SQ_W-1:0];
        sqy_reg <= py[SQ_W-1:0];
        sqz_reg <= pz[SQ_W-1:0];
        sum_reg <= sum_next;
    end

    assign res_tag  = s2_tag_reg;
    assign res_dist = DIST_W'(sum_reg);
    assign busy     = s1_tag_reg.valid | s2_tag_reg.valid;

endmodule

/* rtl/brute_force_nearest_neighbor_core.sv */
// ----------------------------------------------------------------------------
// brute_force_nearest_neighbor_core
// Brute force 3d nearest neighbor search over a store of Q8.8 reference
// points. Clear and load commands complete on acceptance. A query reads the
// stored points one per cycle from the single read port of the point ram and
// feeds them through one pipelined squared distance unit followed by a
// compare against the running best. A query keeps the block busy, taking no
// command, until every stored point has passed the distance unit and the
// previous result has left the output register. The point store needs no
// clearing pass after reset. The cutoff register may be written whenever the
// block is idle.
// ----------------------------------------------------------------------------
module brute_force_nearest_neighbor_core import bfnn_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    bfnn_cmd_if.sink      cmd,
    bfnn_result_if.source result,
    bfnn_cfg_if.sink      cfg
);

    bfnn_state_t state_reg;
    bfnn_state_t state_next;

    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CNT_W-1:0]       issue_reg;
    logic [CNT_W-1:0]       issue_next;
    logic [DIST_W-1:0]      cutoff_reg;
    coord_t                 qx_reg;
    coord_t                 qy_reg;
    coord_t                 qz_reg;
    logic [DIST_W-1:0]      best_dist_reg;
    logic [DIST_W-1:0]      best_dist_next;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [IDX_W-1:0]       best_idx_next;
    logic                   hit_reg;
    logic                   hit_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [MATCH_IDX_W-1:0] out_idx_reg;
    logic [DIST_W-1:0]      out_dist_reg;
    logic                   out_found_reg;
    bfnn_tag_t              rd_tag_reg;
    bfnn_tag_t              rd_tag_next;

    logic               accept;
    logic               is_query;
    logic               ram_we;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [POINT_W-1:0] ram_rdata;
    logic               scan_done;
    logic               out_free;
    logic               out_load;
    bfnn_tag_t          res_tag;
    logic [DIST_W-1:0]  res_dist;
    logic               dist_busy;

    assign accept   = cmd.valid && cmd.ready;
    assign is_query = (cmd.opcode == OP_QUERY);
    assign out_free = !out_valid_reg || result.ready;

    // point store, x in the top bits
    bfnn_ram #(
        .WIDTH (POINT_W),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata ({cmd.coord_x, cmd.coord_y, cmd.coord_z}),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfnn_dist u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tag   (rd_tag_reg),
        .qx       (qx_reg),
        .qy       (qy_reg),
        .qz       (qz_reg),
        .rx       (ram_rdata[3*COORD_W-1:2*COORD_W]),
        .ry       (ram_rdata[2*COORD_W-1:COORD_W]),
        .rz       (ram_rdata[COORD_W-1:0]),
        .res_tag  (res_tag),
        .res_dist (res_dist),
        .busy     (dist_busy)
    );

    assign scan_done = (issue_reg == count_reg) && !rd_tag_reg.valid && !dist_busy;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_query)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        cmd.ready = 1'b0;
        ram_re    = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            ST_SCAN:
            begin
                ram_re = (issue_reg != count_reg);
            end
            ST_FIN:
            begin
                out_load = out_free;
            end
            default:
            begin
                cmd.ready = 1'b0;
            end
        endcase
    end

    assign ram_raddr = issue_reg[IDX_W-1:0];
    assign ram_we    = accept && (cmd.opcode == OP_LOAD)
                       && (count_reg != CNT_W'(MAX_POINTS));

    always_comb
    begin
        count_next     = count_reg;
        issue_next     = issue_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg;
        rd_tag_next    = '{valid: ram_re, idx: ram_raddr};

        if (accept && (cmd.opcode == OP_CLEAR))
        begin
            count_next = '0;
        end
        if (ram_we)
        begin
            count_next = count_reg + CNT_W'(1);
        end

        if (accept && is_query)
        begin
            issue_next     = '0;
            best_dist_next = cutoff_reg;
            best_idx_next  = '0;
            hit_next       = 1'b0;
        end
        if (ram_re)
        begin
            issue_next = issue_reg + CNT_W'(1);
        end
        if (res_tag.valid && (res_dist < best_dist_reg))
        begin
            best_dist_next = res_dist;
            best_idx_next  = res_tag.idx;
            hit_next       = 1'b1;
        end

        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= '0;
            cutoff_reg    <= CUTOFF_RESET;
            out_valid_reg <= 1'b0;
            rd_tag_reg    <= '0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            out_valid_reg <= out_valid_next;
            rd_tag_reg    <= rd_tag_next;
            hit_reg       <= hit_next;
            if (cfg.valid && cfg.ready)
            begin
                cutoff_reg <= cfg.data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        if (accept && is_query)
        begin
            qx_reg <= cmd.coord_x;
            qy_reg <= cmd.coord_y;
            qz_reg <= cmd.coord_z;
        end
        if (out_load)
        begin
            out_idx_reg   <= MATCH_IDX_W'(best_idx_reg);
            out_dist_reg  <= best_dist_reg;
            out_found_reg <= hit_reg;
        end
    end

    assign cfg.ready             = 1'b1;
    assign result.valid          = out_valid_reg;
    assign result.match_index    = out_idx_reg;
    assign result.match_distance = out_dist_reg;
    assign result.found          = out_found_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count above store depth");

    a_issue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (issue_reg <= count_reg))
        else $error("scan index past point count");

    a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_tag_reg.valid || dist_busy) |-> (state_reg == ST_SCAN))
        else $error("distance pipeline active outside scan");

    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && !out_found_reg |-> (out_idx_reg == '0))
        else $error("miss reported with nonzero index");

    a_load_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("result not presented after scan end");
`endif

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench of the brute force nearest neighbor core. A short table of
// commands covers the field extremes, the cutoff boundary, ties, clears and
// the unused opcode. Random phases follow: each one sets a new cutoff, then
// loads a small store and queries it, mostly at or near stored points. A last
// phase fills the store, pushes loads past its end and probes far indices.
// Results are checked field by field against a table row's match, or else a
// predictor with its own copy of the point store and cutoff. Commands mostly
// come in random bursts and gaps; the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bfnn_pkg::*;

    localparam logic [OP_W-1:0]   OP_UNUSED    = 2'd3;
    localparam logic [DIST_W-1:0] CUTOFF_HIGH  = 36'd51538034700;
    localparam logic [DIST_W-1:0] FAR_DIST     = 36'd12884508675;
    localparam coord_t            C_MIN        = 16'sh8000;
    localparam coord_t            C_MAX        = 16'sh7fff;
    localparam int                RANDOM_ITEMS = 500;
    localparam int                IDLE_CYCLES  = 16;
    localparam int                LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic [MATCH_IDX_W-1:0] index;
        logic [DIST_W-1:0]      distance;
        logic                   found;
    } match_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        coord_t          x;
        coord_t          y;
        coord_t          z;
    } point_cmd_t;

    typedef struct {
        bit                is_cfg;
        logic [DIST_W-1:0] cutoff;
        point_cmd_t        cmd;
        bit                typed;
        match_t            want;
    } dir_row_t;

    logic clk;
    logic rst_n;

    bfnn_cmd_if    cmd_if ();
    bfnn_result_if res_if ();
    bfnn_cfg_if    cfg_if ();

    brute_force_nearest_neighbor_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    coord_t            store_x [MAX_POINTS];
    coord_t            store_y [MAX_POINTS];
    coord_t            store_z [MAX_POINTS];
    int unsigned       stored_count = 0;
    logic [DIST_W-1:0] cutoff_now   = CUTOFF_RESET;
    match_t            pending_matches [$];
    dir_row_t          dir_rows [$];

    int errors        = 0;
    int cycles        = 0;
    int items_done    = 0;
    int queries_sent  = 0;
    int results_seen  = 0;
    int hits_seen     = 0;
    int cutoff_writes = 0;
    int ignored_loads = 0;
    int burst_left    = 0;
    bit gaps_on       = 1'b1;

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("brute_force_nearest_neighbor_core test failed");
            $finish;
        end
    end

    // nearest stored point below the cutoff, earliest index wins a tie
    function automatic match_t nearest_match(input point_cmd_t q);
        match_t m;
        longint best;
        longint d;
        longint dx;
        longint dy;
        longint dz;
        m = '0;
        best = longint'(cutoff_now);
        for (int i = 0; i < int'(stored_count); i++)
        begin
            dx = longint'(q.x) - longint'(store_x[i]);
            dy = longint'(q.y) - longint'(store_y[i]);
            dz = longint'(q.z) - longint'(store_z[i]);
            d  = dx * dx + dy * dy + dz * dz;
            if (d < best)
            begin
                best    = d;
                m.index = MATCH_IDX_W'(i);
                m.found = 1'b1;
            end
        end
        m.distance = DIST_W'(best);
        return m;
    endfunction

    function automatic point_cmd_t make_cmd(input logic [OP_W-1:0] op, input coord_t x,
                                            input coord_t y, input coord_t z);
        point_cmd_t c;
        c.op = op;
        c.x  = x;
        c.y  = y;
        c.z  = z;
        return c;
    endfunction

    function automatic coord_t pick_coord(input bit near_origin);
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return C_MIN;
        if (r == 1)
            return C_MAX;
        if (near_origin)
            return coord_t'(int'($urandom_range(0, 2048)) - 1024);
        return coord_t'($urandom);
    endfunction

    function automatic point_cmd_t random_cmd(input logic [OP_W-1:0] op, input bit near);
        return make_cmd(op, pick_coord(near), pick_coord(near), pick_coord(near));
    endfunction

    function automatic void add_cmd_row(input logic [OP_W-1:0] op, input coord_t x,
                                        input coord_t y, input coord_t z);
        dir_row_t r;
        r.is_cfg = 1'b0;
        r.cutoff = '0;
        r.cmd    = make_cmd(op, x, y, z);
        r.typed  = 1'b0;
        r.want   = '0;
        dir_rows = {dir_rows, r};
    endfunction

    function automatic void add_query_row(input coord_t x, input coord_t y, input coord_t z,
                                          input int idx, input logic [DIST_W-1:0] want_dist,
                                          input bit hit);
        dir_row_t r;
        r.is_cfg = 1'b0;
        r.cutoff = '0;
        r.cmd    = make_cmd(OP_QUERY, x, y, z);
        r.typed  = 1'b1;
        r.want   = '{MATCH_IDX_W'(idx), want_dist, hit};
        dir_rows = {dir_rows, r};
    endfunction

    function automatic void add_cfg_row(input logic [DIST_W-1:0] value);
        dir_row_t r;
        r.is_cfg = 1'b1;
        r.cutoff = value;
        r.cmd    = '0;
        r.typed  = 1'b0;
        r.want   = '0;
        dir_rows = {dir_rows, r};
    endfunction

    task automatic hold_cmd(input int n);
        repeat (n)
        begin
            @(negedge clk);
            cmd_if.valid <= 1'b0;
        end
    endtask

    task automatic send_cmd(input point_cmd_t c, input bit typed, input match_t want);
        match_t expect_m;
        @(negedge clk);
        cmd_if.valid   <= 1'b1;
        cmd_if.opcode  <= c.op;
        cmd_if.coord_x <= c.x;
        cmd_if.coord_y <= c.y;
        cmd_if.coord_z <= c.z;
        do
            @(posedge clk);
        while (!cmd_if.ready);
        case (c.op)
            OP_CLEAR:
            begin
                stored_count = 0;
                items_done++;
            end
            OP_LOAD:
            begin
                if (stored_count < MAX_POINTS)
                begin
                    store_x[stored_count] = c.x;
                    store_y[stored_count] = c.y;
                    store_z[stored_count] = c.z;
                    stored_count++;
                    items_done++;
                end
                else
                    ignored_loads++;
            end
            OP_QUERY:
            begin
                expect_m = typed ? want : nearest_match(c);
                pending_matches = {pending_matches, expect_m};
                queries_sent++;
                items_done++;
            end
            default:
            begin
            end
        endcase
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 10);
                hold_cmd($urandom_range(1, 6));
            end
            else
                burst_left--;
        end
    endtask

    // query at a stored point, near one, or anywhere
    task automatic send_query(input bit near);
        point_cmd_t c;
        int j;
        int r;
        r = $urandom_range(0, 9);
        c = random_cmd(OP_QUERY, near);
        if (stored_count != 0 && r < 7)
        begin
            j = $urandom_range(0, stored_count - 1);
            c.x = store_x[j];
            c.y = store_y[j];
            c.z = store_z[j];
            if (r >= 4)
            begin
                c.x = c.x + coord_t'(int'($urandom_range(0, 64)) - 32);
                c.y = c.y + coord_t'(int'($urandom_range(0, 64)) - 32);
                c.z = c.z + coord_t'(int'($urandom_range(0, 64)) - 32);
            end
        end
        send_cmd(c, 1'b0, '0);
    endtask

    task automatic drain_results;
        hold_cmd(1);
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cutoff(input logic [DIST_W-1:0] value);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cutoff_now = value;
        cutoff_writes++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // result side stall pattern
    initial
    begin
        logic [15:0] stall_pat;
        int span;
        stall_pat = 16'hffff;
        span = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                span = $urandom_range(50, 300);
                if ($urandom_range(0, 3) == 0)
                    stall_pat = 16'hffff;
                else
                    stall_pat = 16'($urandom);
                if (stall_pat == 16'h0000)
                    stall_pat = 16'h0001;
            end
            span--;
            stall_pat = {stall_pat[14:0], stall_pat[15]};
            res_if.ready <= stall_pat[0];
        end
    end

    always @(posedge clk)
    begin
        match_t got;
        match_t want;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = '{res_if.match_index, res_if.match_distance, res_if.found};
            results_seen++;
            if (got.found)
                hits_seen++;
            if (pending_matches.size() == 0)
            begin
                $display("%0t: unexpected result index %0d distance %0d found %0b",
                         $time, got.index, got.distance, got.found);
                errors++;
            end
            else
            begin
                want = pending_matches.pop_front();
                if (got.index !== want.index)
                begin
                    $display("%0t: match_index expected %0d actual %0d",
                             $time, want.index, got.index);
                    errors++;
                end
                if (got.distance !== want.distance)
                begin
                    $display("%0t: match_distance expected %0d actual %0d",
                             $time, want.distance, got.distance);
                    errors++;
                end
                if (got.found !== want.found)
                begin
                    $display("%0t: found expected %0b actual %0b",
                             $time, want.found, got.found);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        point_cmd_t        spare;
        logic [DIST_W-1:0] cut;
        int                n_loads;
        int                n_queries;
        bit                near;
        int                probes [5];

        rst_n          = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.opcode  = OP_CLEAR;
        cmd_if.coord_x = '0;
        cmd_if.coord_y = '0;
        cmd_if.coord_z = '0;
        cfg_if.valid   = 1'b0;
        cfg_if.data    = '0;

        add_query_row(0, 0, 0, 0, CUTOFF_RESET, 1'b0);
        add_cmd_row(OP_UNUSED, C_MAX, C_MIN, C_MAX);
        add_cmd_row(OP_LOAD, 0, 0, 0);
        add_cmd_row(OP_LOAD, C_MIN, C_MIN, C_MIN);
        add_cmd_row(OP_LOAD, C_MAX, C_MAX, C_MAX);
        add_query_row(0, 0, 0, 0, 36'd0, 1'b1);
        add_query_row(16'sh0100, 0, 0, 0, 36'd65536, 1'b1);
        add_query_row(16'sh0a00, 0, 0, 0, CUTOFF_RESET, 1'b0);
        add_query_row(16'sh09ff, 0, 0, 0, 36'd6548481, 1'b1);
        add_cmd_row(OP_LOAD, 0, 0, 0);
        add_query_row(16'sh0001, 0, 0, 0, 36'd1, 1'b1);
        add_query_row(C_MAX, C_MAX, C_MAX, 2, 36'd0, 1'b1);
        add_query_row(C_MIN, C_MIN, C_MIN, 1, 36'd0, 1'b1);
        add_cmd_row(OP_CLEAR, C_MAX, C_MAX, C_MAX);
        add_query_row(0, 0, 0, 0, CUTOFF_RESET, 1'b0);
        add_cmd_row(OP_LOAD, C_MAX, C_MIN, 16'sh5555);
        add_cmd_row(OP_LOAD, 16'sh1234, 16'shfbdf, 16'sh00ff);
        add_cmd_row(OP_QUERY, 16'sh1200, 16'shfc00, 16'sh0100);
        add_cfg_row(CUTOFF_HIGH);
        add_cmd_row(OP_CLEAR, 0, 0, 0);
        add_cmd_row(OP_LOAD, C_MIN, C_MIN, C_MIN);
        add_query_row(C_MAX, C_MAX, C_MAX, 0, FAR_DIST, 1'b1);
        add_cfg_row('0);
        add_query_row(C_MIN, C_MIN, C_MIN, 0, 36'd0, 1'b0);
        add_cfg_row(CUTOFF_RESET);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                drain_results;
                write_cutoff(dir_rows[i].cutoff);
            end
            else
                send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
        end

        // random phases, each under a fresh cutoff
        items_done = 0;
        while (items_done < RANDOM_ITEMS)
        begin
            drain_results;
            case ($urandom_range(0, 9))
                0: cut = '0;
                1: cut = CUTOFF_HIGH;
                2: cut = CUTOFF_RESET;
                3, 4: cut = DIST_W'({$urandom, $urandom} % (64'(CUTOFF_HIGH) + 64'd1));
                default: cut = DIST_W'($urandom_range(0, 1 << 24));
            endcase
            write_cutoff(cut);
            gaps_on = ($urandom_range(0, 3) != 0);
            near    = ($urandom_range(0, 3) != 0);
            if (stored_count > 200 || $urandom_range(0, 4) != 0)
                send_cmd(random_cmd(OP_CLEAR, 1'b0), 1'b0, '0);
            n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64)
                                                   : $urandom_range(1, 12);
            repeat (n_loads) send_cmd(random_cmd(OP_LOAD, near), 1'b0, '0);
            n_queries = $urandom_range(1, 6);
            repeat (n_queries)
            begin
                case ($urandom_range(0, 19))
                    0: send_cmd(random_cmd(OP_UNUSED, 1'b0), 1'b0, '0);
                    1: send_cmd(random_cmd(OP_LOAD, near), 1'b0, '0);
                    2: drain_results;
                    default:
                    begin
                    end
                endcase
                send_query(near);
            end
        end

        // full store, loads past the end, probes at far indices
        drain_results;
        write_cutoff(CUTOFF_HIGH);
        gaps_on = 1'b0;
        send_cmd(random_cmd(OP_CLEAR, 1'b0), 1'b0, '0);
        while (stored_count < MAX_POINTS)
            send_cmd(random_cmd(OP_LOAD, 1'b0), 1'b0, '0);
        spare = random_cmd(OP_LOAD, 1'b0);
        repeat (3) send_cmd(spare, 1'b0, '0);
        gaps_on = 1'b1;
        probes = '{MAX_POINTS - 1, 0, 341, 682, 512};
        foreach (probes[i])
            send_cmd(make_cmd(OP_QUERY, store_x[probes[i]], store_y[probes[i]],
                              store_z[probes[i]]), 1'b0, '0);
        send_cmd(make_cmd(OP_QUERY, spare.x, spare.y, spare.z), 1'b0, '0);
        repeat (2) send_query(1'b0);
        drain_results;

        $display("covered %0d queries, %0d results, %0d of them hits, under %0d cutoff writes",
                 queries_sent, results_seen, hits_seen, cutoff_writes);
        $display("store filled to %0d points, %0d loads past the end dropped",
                 stored_count, ignored_loads);
        if (errors == 0)
            $display("brute_force_nearest_neighbor_core test passed");
        else
            $display("brute_force_nearest_neighbor_core test failed");
        $finish;
    end

endmodule

/* sim.f */
rtl/bfnn_pkg.sv
rtl/bfnn_if.sv
rtl/bfnn_ram.sv
rtl/bfnn_dist.sv
rtl/brute_force_nearest_neighbor_core.sv
dv/tb.sv
